// File: design/adc_channel_scan_sequencer_top_defines.svh
// assertion macros shared by the scan sequencer
`ifndef ADC_CHANNEL_SCAN_SEQUENCER_TOP_DEFINES_SVH
`define ADC_CHANNEL_SCAN_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/adc_scan_pkg.sv
package adc_scan_pkg;

    // widths fixed by the item fields
    localparam int MASK_BITS   = 8;
    localparam int CH_BITS     = 3;
    localparam int VALUE_BITS  = 10;
    localparam int POS_BITS    = 4;
    localparam int STATUS_BITS = 2;
    localparam int CTRL_BITS   = 8;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 8;
    localparam int PRESCALE_BITS = 3;

    // request action codes
    localparam logic ACT_START    = 1'b0;
    localparam logic ACT_COMPLETE = 1'b1;

    // converter control byte fields
    localparam logic [CTRL_BITS-1:0] CTRL_ENABLE_START = 8'hC0;
    localparam logic [CTRL_BITS-1:0] CTRL_IRQ_ENABLE   = 8'h08;
    localparam logic [PRESCALE_BITS-1:0] PRESCALE_RESET = 3'd7;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_AUTO_POWER_OFF   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PRESCALER_SELECT = 2'd1;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_OK           = 2'd0,
        STATUS_BUSY         = 2'd1,
        STATUS_EMPTY        = 2'd2,
        STATUS_IDLE_IGNORED = 2'd3
    } status_t;

    typedef struct packed {
        status_t                 status;
        logic                    busy_res;
        logic                    start_conv;
        logic [CH_BITS-1:0]      mux_select;
        logic [CTRL_BITS-1:0]    control_byte;
        logic                    write_valid;
        logic [CH_BITS-1:0]      write_index;
        logic [VALUE_BITS-1:0]   write_value;
        logic                    sequence_done;
        logic                    power_off;
    } result_t;

    typedef struct packed {
        logic               found;
        logic [CH_BITS-1:0] channel;
    } pick_t;

    // lowest set bit of the channel set at or above a start position
    function automatic pick_t find_first(input logic [MASK_BITS-1:0] set,
                                         input logic [POS_BITS-1:0] from);
        pick_t pick;
        pick = '0;
        for (int i = 0; i < MASK_BITS; i++) begin
            if (!pick.found && set[i] && (POS_BITS'(i) >= from)) begin
                pick.found   = 1'b1;
                pick.channel = CH_BITS'(i);
            end
        end
        return pick;
    endfunction

endpackage

// File: design/adc_scan_req_if.sv
interface adc_scan_req_if;
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic [adc_scan_pkg::MASK_BITS-1:0]  channel_mask;
    logic [adc_scan_pkg::VALUE_BITS-1:0] sample_value;

    modport source (output valid, output action, output channel_mask,
                    output sample_value, input ready);
    modport sink   (input valid, input action, input channel_mask,
                    input sample_value, output ready);
endinterface

// File: design/adc_scan_res_if.sv
interface adc_scan_res_if;
    logic                                 valid;
    logic                                 ready;
    logic [adc_scan_pkg::STATUS_BITS-1:0] status;
    logic                                 busy_res;
    logic                                 start_conv;
    logic [adc_scan_pkg::CH_BITS-1:0]     mux_select;
    logic [adc_scan_pkg::CTRL_BITS-1:0]   control_byte;
    logic                                 write_valid;
    logic [adc_scan_pkg::CH_BITS-1:0]     write_index;
    logic [adc_scan_pkg::VALUE_BITS-1:0]  write_value;
    logic                                 sequence_done;
    logic                                 power_off;

    modport source (output valid, output status, output busy_res, output start_conv,
                    output mux_select, output control_byte, output write_valid,
                    output write_index, output write_value, output sequence_done,
                    output power_off, input ready);
    modport sink   (input valid, input status, input busy_res, input start_conv,
                    input mux_select, input control_byte, input write_valid,
                    input write_index, input write_value, input sequence_done,
                    input power_off, output ready);
endinterface

// File: design/adc_scan_cfg_if.sv
interface adc_scan_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [adc_scan_pkg::CFG_IDX_BITS-1:0]  index;
    logic [adc_scan_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/adc_channel_scan_sequencer_top.sv
// Channel scan sequencer for a multichannel converter.
// req channel: action 0 is a start request carrying channel_mask, action 1 is
// a conversion-complete event carrying sample_value.
// res channel: one result per request: status, busy flag, the next converter
// start (mux_select, control_byte), the result buffer write (write_index,
// write_value) and the end-of-scan flags sequence_done and power_off.
// cfg channel: register writes, index 0 auto_power_off, index 1
// prescaler_select; always ready; the user writes it only while the block
// is idle, which the block itself does not enforce. Results are registered.
// Throughput: one request per cycle while the skid entry is empty; the
// next-channel search is a single find-first over the eight-bit channel set
// between the scan state registers and the result register.
// Stall: a result register plus one skid entry; with both full req.ready
// drops until res.ready drains a result. Nothing is dropped or repeated.
// Reset: scan idle, empty channel set, auto power-off cleared, prescaler 7,
// no result pending. Requests are taken from the first cycle after reset.
`include "adc_channel_scan_sequencer_top_defines.svh"

module adc_channel_scan_sequencer_top #(
    parameter int NUM_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    adc_scan_req_if.sink          req,
    adc_scan_res_if.source        res,
    adc_scan_cfg_if.sink          cfg
);

    localparam int MASK_BITS  = adc_scan_pkg::MASK_BITS;
    localparam int VALUE_BITS = adc_scan_pkg::VALUE_BITS;
    localparam int POS_BITS   = adc_scan_pkg::POS_BITS;
    localparam int CH_BITS    = adc_scan_pkg::CH_BITS;
    localparam int SCAN_CH    = (NUM_CHANNELS < MASK_BITS) ? NUM_CHANNELS : MASK_BITS;
    localparam logic [MASK_BITS-1:0] CH_LIMIT =
        MASK_BITS'((64'd1 << SCAN_CH) - 64'd1);
    localparam int SAMPLE_KEEP = (SAMPLE_BITS < VALUE_BITS) ? SAMPLE_BITS : VALUE_BITS;
    localparam logic [VALUE_BITS-1:0] SAMPLE_MASK =
        VALUE_BITS'((64'd1 << SAMPLE_KEEP) - 64'd1);

    // configuration
    logic                                     auto_power_off_reg;
    logic [adc_scan_pkg::PRESCALE_BITS-1:0]   prescaler_select_reg;

    // scan state
    logic                  running_reg, running_next;
    logic [MASK_BITS-1:0]  channel_set_reg, channel_set_next;
    logic [POS_BITS-1:0]   scan_position_reg, scan_position_next;
    logic [POS_BITS-1:0]   result_slot_reg, result_slot_next;

    // result register and skid entry
    logic                  out_valid_reg;
    logic                  skid_valid_reg;
    adc_scan_pkg::result_t out_reg;
    adc_scan_pkg::result_t skid_reg;
    adc_scan_pkg::result_t result_next;

    logic                  in_xfer;
    logic                  out_xfer;
    logic [MASK_BITS-1:0]  mask_in;
    logic [VALUE_BITS-1:0] sample_in;
    adc_scan_pkg::pick_t   first_pick;
    adc_scan_pkg::pick_t   next_pick;

    assign in_xfer   = req.valid && req.ready;
    assign out_xfer  = res.valid && res.ready;
    assign req.ready = !skid_valid_reg;
    assign cfg.ready = 1'b1;

    assign mask_in    = req.channel_mask & CH_LIMIT;
    assign sample_in  = req.sample_value & SAMPLE_MASK;
    assign first_pick = adc_scan_pkg::find_first(mask_in, '0);
    assign next_pick  = adc_scan_pkg::find_first(channel_set_reg, scan_position_reg);

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_power_off_reg   <= 1'b0;
            prescaler_select_reg <= adc_scan_pkg::PRESCALE_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            if (cfg.index == adc_scan_pkg::CFG_AUTO_POWER_OFF)
            begin
                auto_power_off_reg <= cfg.data[0];
            end
            else if (cfg.index == adc_scan_pkg::CFG_PRESCALER_SELECT)
            begin
                prescaler_select_reg <= cfg.data[adc_scan_pkg::PRESCALE_BITS-1:0];
            end
        end
    end

    // per-item sequencing and result formation
    always_comb
    begin
        running_next       = running_reg;
        channel_set_next   = channel_set_reg;
        scan_position_next = scan_position_reg;
        result_slot_next   = result_slot_reg;
        result_next        = '0;
        result_next.status = adc_scan_pkg::STATUS_OK;

        if (req.action == adc_scan_pkg::ACT_START)
        begin
            priority if (running_reg)
            begin
                result_next.status = adc_scan_pkg::STATUS_BUSY;
            end
            else if (mask_in == '0)
            begin
                result_next.status = adc_scan_pkg::STATUS_EMPTY;
            end
            else
            begin
                channel_set_next       = mask_in;
                result_slot_next       = '0;
                running_next           = 1'b1;
                result_next.start_conv = 1'b1;
                result_next.mux_select = first_pick.channel;
                scan_position_next     = POS_BITS'({1'b0, first_pick.channel}) + 1'b1;
            end
        end
        else
        begin
            if (!running_reg)
            begin
                result_next.status = adc_scan_pkg::STATUS_IDLE_IGNORED;
            end
            else
            begin
                result_next.write_valid = 1'b1;
                result_next.write_index = result_slot_reg[CH_BITS-1:0];
                result_next.write_value = sample_in;
                result_slot_next        = result_slot_reg + 1'b1;
                if (next_pick.found)
                begin
                    result_next.start_conv = 1'b1;
                    result_next.mux_select = next_pick.channel;
                    scan_position_next     = POS_BITS'({1'b0, next_pick.channel}) + 1'b1;
                end
                else
                begin
                    running_next              = 1'b0;
                    result_next.sequence_done = 1'b1;
                    result_next.power_off     = auto_power_off_reg;
                end
            end
        end

        if (result_next.start_conv)
        begin
            result_next.control_byte = adc_scan_pkg::CTRL_ENABLE_START
                                     | adc_scan_pkg::CTRL_IRQ_ENABLE
                                     | {5'b0, prescaler_select_reg};
        end
        result_next.busy_res = running_next;
    end

    // scan state update on each request transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg       <= 1'b0;
            channel_set_reg   <= '0;
            scan_position_reg <= '0;
            result_slot_reg   <= '0;
        end
        else if (in_xfer)
        begin
            running_reg       <= running_next;
            channel_set_reg   <= channel_set_next;
            scan_position_reg <= scan_position_next;
            result_slot_reg   <= result_slot_next;
        end
    end

    // output register with one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_xfer)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_xfer)
        begin
            if (out_valid_reg && !out_xfer)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_xfer)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload moves
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_xfer)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_xfer)
        begin
            if (out_valid_reg && !out_xfer)
            begin
                skid_reg <= result_next;
            end
            else
            begin
                out_reg <= result_next;
            end
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.status        = out_reg.status;
    assign res.busy_res      = out_reg.busy_res;
    assign res.start_conv    = out_reg.start_conv;
    assign res.mux_select    = out_reg.mux_select;
    assign res.control_byte  = out_reg.control_byte;
    assign res.write_valid   = out_reg.write_valid;
    assign res.write_index   = out_reg.write_index;
    assign res.write_value   = out_reg.write_value;
    assign res.sequence_done = out_reg.sequence_done;
    assign res.power_off     = out_reg.power_off;

    // checks
    `ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid entry without output")
    `ASSERT_SAME(a_run_has_channels, running_reg, channel_set_reg != '0, "scan with empty set")
    `ASSERT_SAME(a_slot_bounded, 1'b1, result_slot_reg <= POS_BITS'(SCAN_CH), "slot overrun")
    `ASSERT_NEXT(a_done_ends_scan, in_xfer && result_next.sequence_done, !running_reg,
                 "scan still running after done")

endmodule
